>>> hw/rtl/utf8_decode_display_width_defines.svh
// Assertion macros shared by the UTF-8 decoder RTL.
`ifndef UTF8_DECODE_DISPLAY_WIDTH_DEFINES_SVH
`define UTF8_DECODE_DISPLAY_WIDTH_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define U8DW_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("u8dw check failed");

// Check that a condition implies a consequence in the same cycle.
`define U8DW_ASSERT_IMPLY(label, cond, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error("u8dw implication failed");

`endif

>>> hw/rtl/u8dw_pkg.sv
// Shared types, constants and width function for the UTF-8 decoder.
package u8dw_pkg;

   localparam longint unsigned MAX_TEXT_BYTES_DEF = 64'd65536;

   localparam int CP_W   = 21;
   localparam int OFF_W  = 16;
   localparam int LEN_W  = 3;
   localparam int DW_W   = 2;
   localparam int RES_MAX = 4;
   localparam int CNT_W  = 3;

   localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

   localparam logic [DW_W-1:0] DW_ZERO = 2'd0;
   localparam logic [DW_W-1:0] DW_ONE  = 2'd1;
   localparam logic [DW_W-1:0] DW_TWO  = 2'd2;

   typedef struct packed {
      logic [CP_W-1:0]  code_point;
      logic [OFF_W-1:0] start_offset;
      logic [LEN_W-1:0] byte_length;
      logic [DW_W-1:0]  display_width;
      logic             is_replacement;
   } result_type;

   typedef struct packed {
      result_type [RES_MAX-1:0] entry;
      logic [CNT_W-1:0]         count;
   } group_type;

   function automatic logic [DW_W-1:0] display_width(input logic [CP_W-1:0] v);
      logic zero;
      logic wide;
      zero = (v == 21'h0)
          || (v >= 21'h0300 && v <= 21'h036F)
          || (v >= 21'hFE00 && v <= 21'hFE0F);
      wide = (v >= 21'h1100 && v <= 21'h115F)
          || (v == 21'h2329) || (v == 21'h232A)
          || (v >= 21'h2E80 && v <= 21'hA4CF && v != 21'h303F)
          || (v >= 21'hAC00 && v <= 21'hD7A3)
          || (v >= 21'hF900 && v <= 21'hFAFF)
          || (v >= 21'hFE10 && v <= 21'hFE19)
          || (v >= 21'hFE30 && v <= 21'hFE6F)
          || (v >= 21'hFF00 && v <= 21'hFF60)
          || (v >= 21'hFFE0 && v <= 21'hFFE6)
          || (v >= 21'h1F300 && v <= 21'h1FAFF)
          || (v >= 21'h20000 && v <= 21'h3FFFD);
      if (zero) begin
         return DW_ZERO;
      end else if (wide) begin
         return DW_TWO;
      end
      return DW_ONE;
   endfunction

   function automatic result_type make_repl(input logic [OFF_W-1:0] offset);
      result_type r;
      r.code_point     = REPL_CP;
      r.start_offset   = offset;
      r.byte_length    = 3'd1;
      r.display_width  = DW_ONE;
      r.is_replacement = 1'b1;
      return r;
   endfunction

endpackage

>>> hw/rtl/u8dw_decoder.sv
// Sequence state registers and single-pass decode of one byte into a result group.
`include "utf8_decode_display_width_defines.svh"

module u8dw_decoder #(
   parameter longint unsigned MAX_TEXT_BYTES = u8dw_pkg::MAX_TEXT_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  logic [7:0]          data_byte,
   input  logic                end_of_text,
   output u8dw_pkg::group_type group
);
   import u8dw_pkg::*;

   localparam logic [OFF_W:0] POS_LIMIT =
      (MAX_TEXT_BYTES >= 64'd65536) ? 17'h10000 : 17'(MAX_TEXT_BYTES);

   typedef enum logic [2:0] {
      LEAD_ASCII,
      LEAD_TWO,
      LEAD_THREE,
      LEAD_FOUR,
      LEAD_BAD
   } lead_type;

   function automatic logic [OFF_W-1:0] advance(input logic [OFF_W-1:0] p);
      logic [OFF_W:0] n;
      n = {1'b0, p} + 17'd1;
      if (n >= POS_LIMIT) begin
         n = '0;
      end
      return n[OFF_W-1:0];
   endfunction

   logic [CP_W-1:0]  partial_value_ff,  partial_value_in;
   logic [1:0]       bytes_expected_ff, bytes_expected_in;
   logic [1:0]       bytes_received_ff, bytes_received_in;
   logic [OFF_W-1:0] sequence_start_ff, sequence_start_in;
   logic [OFF_W-1:0] byte_position_ff,  byte_position_in;

   lead_type         lead;
   logic [CP_W-1:0]  lead_value;
   logic [1:0]       lead_need;
   logic [CP_W-1:0]  joined;
   logic [1:0]       recv_inc;
   logic [OFF_W-1:0] held1;
   logic [OFF_W-1:0] held2;
   logic             do_flush;
   logic [1:0]       flush_count;
   logic             do_tail;
   result_type       tail;
   logic             take_lead;
   logic [CNT_W-1:0] k;

   always_comb begin
      unique case (1'b1)
         (data_byte[7] == 1'b0):        lead = LEAD_ASCII;
         (data_byte[7:5] == 3'b110):    lead = LEAD_TWO;
         (data_byte[7:4] == 4'b1110):   lead = LEAD_THREE;
         (data_byte[7:3] == 5'b11110):  lead = LEAD_FOUR;
         default:                       lead = LEAD_BAD;
      endcase
   end

   always_comb begin
      unique case (lead)
         LEAD_TWO: begin
            lead_need  = 2'd1;
            lead_value = {16'd0, data_byte[4:0]};
         end
         LEAD_THREE: begin
            lead_need  = 2'd2;
            lead_value = {17'd0, data_byte[3:0]};
         end
         LEAD_FOUR: begin
            lead_need  = 2'd3;
            lead_value = {18'd0, data_byte[2:0]};
         end
         default: begin
            lead_need  = 2'd0;
            lead_value = '0;
         end
      endcase
   end

   always_comb begin
      partial_value_in  = partial_value_ff;
      bytes_expected_in = bytes_expected_ff;
      bytes_received_in = bytes_received_ff;
      sequence_start_in = sequence_start_ff;
      byte_position_in  = end_of_text ? '0 : advance(byte_position_ff);

      joined      = {partial_value_ff[CP_W-7:0], data_byte[5:0]};
      recv_inc    = bytes_received_ff + 2'd1;
      held1       = advance(sequence_start_ff);
      held2       = advance(held1);
      do_flush    = 1'b0;
      flush_count = bytes_received_ff;
      do_tail     = 1'b0;
      tail        = make_repl(byte_position_ff);
      take_lead   = 1'b0;

      if (bytes_expected_ff != 2'd0) begin
         if (data_byte[7:6] == 2'b10) begin
            if (recv_inc >= bytes_expected_ff) begin
               do_tail                = 1'b1;
               tail.code_point        = joined;
               tail.start_offset      = sequence_start_ff;
               tail.byte_length       = {1'b0, bytes_expected_ff} + 3'd1;
               tail.display_width     = display_width(joined);
               tail.is_replacement    = 1'b0;
               partial_value_in       = '0;
               bytes_expected_in      = '0;
               bytes_received_in      = '0;
            end else if (end_of_text) begin
               do_flush          = 1'b1;
               flush_count       = recv_inc;
               partial_value_in  = '0;
               bytes_expected_in = '0;
               bytes_received_in = '0;
            end else begin
               partial_value_in  = joined;
               bytes_received_in = recv_inc;
            end
         end else begin
            do_flush          = 1'b1;
            partial_value_in  = '0;
            bytes_expected_in = '0;
            bytes_received_in = '0;
            take_lead         = 1'b1;
         end
      end else begin
         take_lead = 1'b1;
      end

      if (take_lead) begin
         if (lead == LEAD_ASCII) begin
            do_tail             = 1'b1;
            tail.code_point     = {13'd0, data_byte};
            tail.display_width  = display_width({13'd0, data_byte});
            tail.is_replacement = 1'b0;
         end else if (lead == LEAD_BAD || end_of_text) begin
            do_tail = 1'b1;
         end else begin
            partial_value_in  = lead_value;
            bytes_expected_in = lead_need;
            bytes_received_in = '0;
            sequence_start_in = byte_position_ff;
         end
      end

      group = '0;
      k     = '0;
      if (do_flush) begin
         group.entry[0] = make_repl(sequence_start_ff);
         if (flush_count != 2'd0) begin
            group.entry[1] = make_repl(held1);
         end
         if (flush_count == 2'd2) begin
            group.entry[2] = make_repl(held2);
         end
         k = 3'd1 + {1'b0, flush_count};
      end
      if (do_tail) begin
         group.entry[k[1:0]] = tail;
         k = k + 3'd1;
      end
      group.count = k;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_value_ff  <= '0;
         bytes_expected_ff <= '0;
         bytes_received_ff <= '0;
         sequence_start_ff <= '0;
         byte_position_ff  <= '0;
      end else if (fire) begin
         partial_value_ff  <= partial_value_in;
         bytes_expected_ff <= bytes_expected_in;
         bytes_received_ff <= bytes_received_in;
         sequence_start_ff <= sequence_start_in;
         byte_position_ff  <= byte_position_in;
      end
   end

   `U8DW_ASSERT(a_recv_below_need, bytes_expected_ff == 2'd0 || bytes_received_ff < bytes_expected_ff)
   `U8DW_ASSERT_IMPLY(a_idle_clear, bytes_expected_ff == 2'd0, bytes_received_ff == 2'd0 && partial_value_ff == '0)
   `U8DW_ASSERT(a_pos_in_range, 17'(byte_position_ff) < POS_LIMIT && 17'(sequence_start_ff) < POS_LIMIT)

endmodule

>>> hw/rtl/u8dw_result_buf.sv
// Result group register that hands out one word per cycle while rsp_ready is high, oldest first.
`include "utf8_decode_display_width_defines.svh"

module u8dw_result_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  u8dw_pkg::group_type group_in,
   output logic                free,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [20:0]         rsp_code_point,
   output logic [15:0]         rsp_start_offset,
   output logic [2:0]          rsp_byte_length,
   output logic [1:0]          rsp_display_width,
   output logic                rsp_is_replacement,
   output logic                rsp_last_result
);
   import u8dw_pkg::*;

   result_type [RES_MAX-1:0] entry_ff;
   logic [CNT_W-1:0]         count_ff;
   logic                     take;

   assign rsp_valid = (count_ff != '0);
   assign take      = rsp_valid && rsp_ready;
   assign free      = (count_ff == '0) || (count_ff == 3'd1 && rsp_ready);

   assign rsp_code_point     = entry_ff[0].code_point;
   assign rsp_start_offset   = entry_ff[0].start_offset;
   assign rsp_byte_length    = entry_ff[0].byte_length;
   assign rsp_display_width  = entry_ff[0].display_width;
   assign rsp_is_replacement = entry_ff[0].is_replacement;
   assign rsp_last_result    = (count_ff == 3'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (load) begin
         count_ff <= group_in.count;
      end else if (take) begin
         count_ff <= count_ff - 3'd1;
      end
   end

   // advance remaining words toward the head
   always_ff @(posedge clock) begin
      if (load) begin
         entry_ff <= group_in.entry;
      end else if (take) begin
         for (int i = 0; i < RES_MAX - 1; i++) begin
            entry_ff[i] <= entry_ff[i+1];
         end
      end
   end

   `U8DW_ASSERT(a_count_bound, count_ff <= 3'(RES_MAX))
   `U8DW_ASSERT_IMPLY(a_load_when_free, load, free && group_in.count != '0)
   `U8DW_ASSERT_IMPLY(a_hold_stalled, rsp_valid && !rsp_ready, ##1 count_ff == $past(count_ff))

endmodule

>>> hw/rtl/utf8_decode_display_width.sv
// Top level of the UTF-8 decoder with terminal display width.
//
//   channel  direction  handshake              word
//   req_     in         req_valid / req_ready  data_byte, end_of_text
//   rsp_     out        rsp_valid / rsp_ready  code_point .. last_result
//
// One byte enters per cycle while req_ready is high; the decode runs in one
// pass between the input register and the result group register, so the
// first word of a byte is valid in the cycle after the edge that loads the
// group. A byte that yields several words occupies the result group until
// each word is taken; input holds while a multi-word group drains or the
// receiver holds off. Synchronous reset clears the sequence state, the byte
// position and both valid stages; no clearing pass is needed.
module utf8_decode_display_width #(
   parameter longint unsigned MAX_TEXT_BYTES = u8dw_pkg::MAX_TEXT_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [20:0] rsp_code_point,
   output logic [15:0] rsp_start_offset,
   output logic [2:0]  rsp_byte_length,
   output logic [1:0]  rsp_display_width,
   output logic        rsp_is_replacement,
   output logic        rsp_last_result
);
   import u8dw_pkg::*;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_eot_ff;
   logic       fire;
   logic       buf_free;
   group_type  group;

   assign fire      = in_valid_ff && (group.count == '0 || buf_free);
   assign req_ready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
         in_eot_ff  <= req_end_of_text;
      end
   end

   u8dw_decoder #(
      .MAX_TEXT_BYTES(MAX_TEXT_BYTES)
   ) u_decoder (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .data_byte   (in_byte_ff),
      .end_of_text (in_eot_ff),
      .group       (group)
   );

   u8dw_result_buf u_result_buf (
      .clock              (clock),
      .reset              (reset),
      .load               (fire && group.count != '0),
      .group_in           (group),
      .free               (buf_free),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_code_point     (rsp_code_point),
      .rsp_start_offset   (rsp_start_offset),
      .rsp_byte_length    (rsp_byte_length),
      .rsp_display_width  (rsp_display_width),
      .rsp_is_replacement (rsp_is_replacement),
      .rsp_last_result    (rsp_last_result)
   );

endmodule

>>> verif/tb_utf8_decode_display_width.sv
// Testbench for the UTF-8 decoder: directed byte table, then random text, checked per word.
`timescale 1ns / 1ps

module tb_utf8_decode_display_width;
   import u8dw_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int HOLD_CYCLES = 300;
   localparam int NUM_ROWS    = 26;

   typedef struct packed {
      logic [20:0] cp;
      logic [15:0] off;
      logic [2:0]  len;
      logic [1:0]  dw;
      logic        repl;
      logic        last;
   } cp_rec_type;

   typedef struct packed {
      logic [7:0]  data;
      logic        eot;
      logic [16:0] reps;
      logic        typed;
      logic [20:0] cp;
      logic [15:0] off;
      logic [1:0]  dw;
      logic        repl;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_end_of_text = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [20:0] rsp_code_point;
   logic [15:0] rsp_start_offset;
   logic [2:0]  rsp_byte_length;
   logic [1:0]  rsp_display_width;
   logic        rsp_is_replacement;
   logic        rsp_last_result;

   cp_rec_type decoded_q [$];
   cp_rec_type step_out [4];
   int      step_n;
   int      fail_count = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   bit      hold_now = 1'b0;
   bit      hold_taken = 1'b0;
   int      hold_left = 0;
   int      quiet = 0;

   logic [20:0] seq_val = '0;
   logic [1:0]  seq_need = '0;
   logic [1:0]  seq_got = '0;
   logic [15:0] seq_start = '0;
   logic [15:0] text_pos = '0;

   row_type rows [NUM_ROWS] = '{
      '{8'h00, 1'b0, 17'd1, 1'b1, 21'h000000, 16'd0, DW_ZERO, 1'b0},
      '{8'h7F, 1'b0, 17'd1, 1'b1, 21'h00007F, 16'd1, DW_ONE,  1'b0},
      '{8'h80, 1'b0, 17'd1, 1'b1, REPL_CP,    16'd2, DW_ONE,  1'b1},
      '{8'hFF, 1'b0, 17'd1, 1'b1, REPL_CP,    16'd3, DW_ONE,  1'b1},
      '{8'hF8, 1'b0, 17'd1, 1'b1, REPL_CP,    16'd4, DW_ONE,  1'b1},
      '{8'hCC, 1'b0, 17'd1, 1'b0, 21'h0, 16'd0, DW_ZERO, 1'b0},
      '{8'h80, 1'b0, 17'd1, 1'b0, 21'h0, 16'd0, DW_ZERO, 1'b0},
      '{8'hF0, 1'b0, 17'd1, 1'b0, 21'h0, 16'd0, DW_ZERO, 1'b0},
      '{8'h9F, 1'b0, 17'd1, 1'b0, 21'h0, 16'd0, DW_ZERO, 1'b0},
      '{8'h98, 1'b0, 17'd1, 1'b0, 21'h0, 16'd0, DW_ZERO, 1'b0},
      '{8'h80, 1'b0, 17'd1, 1'b0, 21'h0, 16'd0, DW_ZERO, 1'b0},
      '{8'hE3, 1'b0, 17'd1, 1'b0, 21'h0, 16'd0, DW_ZERO, 1'b0},
      '{8'h80, 1'b0, 17'd1, 1'b0, 21'h0, 16'd0, DW_ZERO, 1'b0},
      '{8'h41, 1'b0, 17'd1, 1'b0, 21'h0, 16'd0, DW_ZERO, 1'b0},
      '{8'hF0, 1'b0, 17'd1, 1'b0, 21'h0, 16'd0, DW_ZERO, 1'b0},
      '{8'h80, 1'b0, 17'd1, 1'b0, 21'h0, 16'd0, DW_ZERO, 1'b0},
      '{8'h80, 1'b0, 17'd1, 1'b0, 21'h0, 16'd0, DW_ZERO, 1'b0},
      '{8'hFF, 1'b0, 17'd1, 1'b0, 21'h0, 16'd0, DW_ZERO, 1'b0},
      '{8'hE2, 1'b0, 17'd1, 1'b0, 21'h0, 16'd0, DW_ZERO, 1'b0},
      '{8'h82, 1'b1, 17'd1, 1'b0, 21'h0, 16'd0, DW_ZERO, 1'b0},
      '{8'hC2, 1'b1, 17'd1, 1'b1, REPL_CP, 16'd0, DW_ONE, 1'b1},
      '{8'h61, 1'b0, 17'd1, 1'b0, 21'h0, 16'd0, DW_ZERO, 1'b0},
      '{8'hF7, 1'b0, 17'd1, 1'b0, 21'h0, 16'd0, DW_ZERO, 1'b0},
      '{8'hBF, 1'b0, 17'd1, 1'b0, 21'h0, 16'd0, DW_ZERO, 1'b0},
      '{8'hBF, 1'b0, 17'd1, 1'b0, 21'h0, 16'd0, DW_ZERO, 1'b0},
      '{8'hBF, 1'b1, 17'd1, 1'b0, 21'h0, 16'd0, DW_ZERO, 1'b0}
   };

   utf8_decode_display_width dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_end_of_text    (req_end_of_text),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_code_point     (rsp_code_point),
      .rsp_start_offset   (rsp_start_offset),
      .rsp_byte_length    (rsp_byte_length),
      .rsp_display_width  (rsp_display_width),
      .rsp_is_replacement (rsp_is_replacement),
      .rsp_last_result    (rsp_last_result)
   );

   always #6 clock = ~clock;

   function automatic logic [1:0] column_count(input logic [20:0] v);
      if (v == 21'h0 || (v >= 21'h0300 && v <= 21'h036F) || (v >= 21'hFE00 && v <= 21'hFE0F))
         return DW_ZERO;
      if ((v >= 21'h1100 && v <= 21'h115F) || v == 21'h2329 || v == 21'h232A
          || (v >= 21'h2E80 && v <= 21'h303E) || (v >= 21'h3040 && v <= 21'hA4CF)
          || (v >= 21'hAC00 && v <= 21'hD7A3) || (v >= 21'hF900 && v <= 21'hFAFF)
          || (v >= 21'hFE10 && v <= 21'hFE19) || (v >= 21'hFE30 && v <= 21'hFE6F)
          || (v >= 21'hFF00 && v <= 21'hFF60) || (v >= 21'hFFE0 && v <= 21'hFFE6)
          || (v >= 21'h1F300 && v <= 21'h1FAFF) || (v >= 21'h20000 && v <= 21'h3FFFD))
         return DW_TWO;
      return DW_ONE;
   endfunction

   function automatic void add_point(input logic [20:0] cp, input logic [15:0] off,
                                     input logic [2:0] len, input logic [1:0] dw,
                                     input logic repl);
      step_out[step_n] = '{cp, off, len, dw, repl, 1'b0};
      step_n++;
   endfunction

   function automatic void flush_sequence();
      logic [15:0] p;
      p = seq_start;
      add_point(REPL_CP, p, 3'd1, DW_ONE, 1'b1);
      for (int i = 0; i < seq_got; i++) begin
         p = p + 16'd1;
         add_point(REPL_CP, p, 3'd1, DW_ONE, 1'b1);
      end
      seq_val = '0;
      seq_need = '0;
      seq_got = '0;
   endfunction

   function automatic void take_lead(input logic [7:0] b, input logic [15:0] here,
                                     input bit eot);
      logic [1:0]  need;
      logic [20:0] val;
      if (b[7] == 1'b0) begin
         add_point({13'h0, b}, here, 3'd1, column_count({13'h0, b}), 1'b0);
         return;
      end
      if (b[7:5] == 3'b110) begin
         need = 2'd1;
         val = {16'h0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
         need = 2'd2;
         val = {17'h0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
         need = 2'd3;
         val = {18'h0, b[2:0]};
      end else begin
         add_point(REPL_CP, here, 3'd1, DW_ONE, 1'b1);
         return;
      end
      if (eot) begin
         add_point(REPL_CP, here, 3'd1, DW_ONE, 1'b1);
         return;
      end
      seq_val = val;
      seq_need = need;
      seq_got = '0;
      seq_start = here;
   endfunction

   function automatic void decode_byte(input logic [7:0] b, input bit eot);
      logic [15:0] here;
      here = text_pos;
      step_n = 0;
      if (seq_need != 2'd0) begin
         if (b[7:6] == 2'b10) begin
            seq_val = {seq_val[14:0], b[5:0]};
            seq_got = seq_got + 2'd1;
            if (seq_got >= seq_need) begin
               add_point(seq_val, seq_start, {1'b0, seq_need} + 3'd1, column_count(seq_val),
                         1'b0);
               seq_val = '0;
               seq_need = '0;
               seq_got = '0;
            end else if (eot) begin
               flush_sequence();
            end
         end else begin
            flush_sequence();
            take_lead(b, here, eot);
         end
      end else begin
         take_lead(b, here, eot);
      end
      text_pos = eot ? 16'd0 : here + 16'd1;
      if (step_n > 0)
         step_out[step_n-1].last = 1'b1;
   endfunction

   task automatic send_byte(input logic [7:0] b, input bit eot, input bit typed,
                            input cp_rec_type want);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct && gap < 40)
         gap++;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_end_of_text <= eot;
      do @(posedge clock); while (req_ready !== 1'b1);
      decode_byte(b, eot);
      if (typed) begin
         decoded_q = {decoded_q, want};
      end else begin
         for (int i = 0; i < step_n; i++)
            decoded_q = {decoded_q, step_out[i]};
      end
   endtask

   function automatic logic [20:0] pick_point();
      case ($urandom_range(0, 7))
         0: return 21'($urandom_range(0, 'h7F));
         1: return 21'($urandom_range('h80, 'h7FF));
         2: return 21'($urandom_range('h2F0, 'h37F));
         3: return 21'($urandom_range('h800, 'hFFFF));
         4: return 21'($urandom_range('h10F0, 'h3050));
         5: return 21'($urandom_range('hFDF0, 'hFFFF));
         6: return 21'($urandom_range('h1F000, 'h40000));
         default: return 21'($urandom_range(0, 'h1FFFFF));
      endcase
   endfunction

   task automatic send_point(input logic [20:0] cp, input int len, input int keep);
      logic [7:0] enc [4];
      case (len)
         1: begin
            enc[0] = {1'b0, cp[6:0]};
         end
         2: begin
            enc[0] = {3'b110, cp[10:6]};
            enc[1] = {2'b10, cp[5:0]};
         end
         3: begin
            enc[0] = {4'b1110, cp[15:12]};
            enc[1] = {2'b10, cp[11:6]};
            enc[2] = {2'b10, cp[5:0]};
         end
         default: begin
            enc[0] = {5'b11110, cp[20:18]};
            enc[1] = {2'b10, cp[17:12]};
            enc[2] = {2'b10, cp[11:6]};
            enc[3] = {2'b10, cp[5:0]};
         end
      endcase
      for (int i = 0; i < keep; i++)
         send_byte(enc[i], $urandom_range(0, 11) == 0, 1'b0, '0);
   endtask

   task automatic random_text(input int n);
      int          sent;
      int          pick;
      int          min_len;
      int          len;
      int          keep;
      logic [20:0] cp;
      sent = 0;
      while (sent < n) begin
         pick = $urandom_range(0, 99);
         cp = pick_point();
         min_len = (cp < 'h80) ? 1 : (cp < 'h800) ? 2 : (cp < 'h10000) ? 3 : 4;
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(min_len, 4) : min_len;
         if (pick < 72)
            keep = len;
         else if (pick < 84)
            keep = (len > 1) ? $urandom_range(1, len - 1) : 1;
         else
            keep = 0;
         if (keep == 0) begin
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 11) == 0, 1'b0, '0);
            sent++;
         end else begin
            send_point(cp, len, keep);
            sent += keep;
         end
      end
   endtask

   task automatic check_field(input string name, input logic [20:0] want,
                              input logic [20:0] got);
      if (got !== want) begin
         $error("%s expected %h actual %h", name, want, got);
         fail_count++;
      end
   endtask

   always @(negedge clock) begin
      if (hold_now && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cp_rec_type head;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (decoded_q.size() == 0) begin
            $error("unexpected word, code_point %h", rsp_code_point);
            fail_count++;
         end else begin
            head = decoded_q.pop_front();
            check_field("code_point", head.cp, rsp_code_point);
            check_field("start_offset", {5'h0, head.off}, {5'h0, rsp_start_offset});
            check_field("byte_length", {18'h0, head.len}, {18'h0, rsp_byte_length});
            check_field("display_width", {19'h0, head.dw}, {19'h0, rsp_display_width});
            check_field("is_replacement", {20'h0, head.repl}, {20'h0, rsp_is_replacement});
            check_field("last_result", {20'h0, head.last}, {20'h0, rsp_last_result});
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      cp_rec_type want;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 29;
      recv_idle_pct = 72;
      for (int i = 0; i < NUM_ROWS; i++) begin
         want = '{rows[i].cp, rows[i].off, 3'd1, rows[i].dw, rows[i].repl, 1'b1};
         for (int k = 0; k < rows[i].reps; k++)
            send_byte(rows[i].data, rows[i].eot, rows[i].typed, want);
      end
      random_text(52);

      send_idle_pct = 72;
      recv_idle_pct = 29;
      random_text(52);

      // hold the result side so the input backs up
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_now = 1'b1;
      random_text(52);

      @(negedge clock);
      req_valid <= 1'b0;
      while (decoded_q.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
